[design/vtsi_pkg.sv]
// types and constants shared by the vlan tag strip/insert block
// no dependencies

package vtsi_pkg;

  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned HELD_DEPTH  = 4;

  localparam logic [15:0] TPID_CTAG = 16'h8100;
  localparam logic [15:0] TPID_STAG = 16'h88A8;

  localparam logic [POS_W-1:0] POS_ET_HI  = 5'd12;
  localparam logic [POS_W-1:0] POS_ET_LO  = 5'd13;
  localparam logic [POS_W-1:0] POS_TAG_2  = 5'd14;
  localparam logic [POS_W-1:0] POS_TAG_3  = 5'd15;
  localparam logic [POS_W-1:0] POS_INNER  = 5'd16;
  localparam logic [POS_W-1:0] POS_SAT    = 5'd18;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // one accepted byte turned into a burst of up to six output bytes
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] data;
    logic [CNT_W-1:0]            count;
    logic                        last;
  } cmd_t;

endpackage

[design/vtsi_front.sv]
// front end: byte position tracking, ethertype classification, held bytes
// depends on vtsi_pkg

module vtsi_front import vtsi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  in_item_t    in_item,
  input  logic        q_full,
  output logic        in_stall,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output logic        push_valid,
  output cmd_t        push_cmd
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             tagged_r, tagged_nxt;
  logic [15:0]      push_tci_r;
  logic [HELD_DEPTH-1:0][7:0] held_r, held_nxt;
  logic             accept;
  logic [7:0]       b;
  logic             last;
  logic             et_tagged;
  cmd_t             cmd;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_item.in_byte;
  assign last     = in_item.in_last;
  assign et_tagged = ({held_r[0], b} == TPID_CTAG) || ({held_r[0], b} == TPID_STAG);

  always_comb begin
    cmd        = '0;
    cmd.last   = last;
    held_nxt   = held_r;
    tagged_nxt = tagged_r;
    if (pos_r < POS_ET_HI) begin
      cmd.data[0] = b;
      cmd.count   = CNT_W'(1);
    end else if (pos_r == POS_ET_HI) begin
      held_nxt[0] = b;
      cmd.data[0] = b;
      cmd.count   = last ? CNT_W'(1) : CNT_W'(0);
    end else if (pos_r == POS_ET_LO) begin
      held_nxt[1] = b;
      tagged_nxt  = et_tagged;
      if (!et_tagged) begin
        cmd.data[0] = TPID_CTAG[15:8];
        cmd.data[1] = TPID_CTAG[7:0];
        cmd.data[2] = push_tci_r[15:8];
        cmd.data[3] = push_tci_r[7:0];
        cmd.data[4] = held_r[0];
        cmd.data[5] = b;
        cmd.count   = CNT_W'(6);
      end else begin
        cmd.data[0] = held_r[0];
        cmd.data[1] = b;
        cmd.count   = last ? CNT_W'(2) : CNT_W'(0);
      end
    end else if (pos_r == POS_TAG_2 && tagged_r) begin
      held_nxt[2] = b;
      cmd.data[0] = held_r[0];
      cmd.data[1] = held_r[1];
      cmd.data[2] = b;
      cmd.count   = last ? CNT_W'(3) : CNT_W'(0);
    end else if (pos_r == POS_TAG_3 && tagged_r) begin
      held_nxt[3] = b;
      cmd.data[0] = held_r[0];
      cmd.data[1] = held_r[1];
      cmd.data[2] = held_r[2];
      cmd.data[3] = b;
      cmd.count   = last ? CNT_W'(4) : CNT_W'(0);
    end else if (pos_r == POS_INNER && tagged_r && last) begin
      cmd.data[0] = held_r[0];
      cmd.data[1] = held_r[1];
      cmd.data[2] = held_r[2];
      cmd.data[3] = held_r[3];
      cmd.data[4] = b;
      cmd.count   = CNT_W'(5);
    end else begin
      cmd.data[0] = b;
      cmd.count   = CNT_W'(1);
    end

    if (last) begin
      pos_nxt    = '0;
      tagged_nxt = 1'b0;
    end else if (pos_r < POS_SAT) begin
      pos_nxt = pos_r + 1'b1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  assign push_valid = accept && (cmd.count != '0);
  assign push_cmd   = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      tagged_r   <= 1'b0;
      push_tci_r <= 16'd1;
    end else begin
      if (accept) begin
        pos_r    <= pos_nxt;
        tagged_r <= tagged_nxt;
      end
      if (cfg_wr_en) begin
        push_tci_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule

[design/vtsi_cmd_fifo.sv]
// small command queue between front and back ends
// depends on vtsi_pkg

module vtsi_cmd_fifo import vtsi_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[design/vtsi_back.sv]
// back end: serializes queued commands into output bytes, output register
// depends on vtsi_pkg

module vtsi_back import vtsi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  cmd_t      head_cmd,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_stall
);

  logic [CNT_W-1:0] idx_r;
  logic             out_valid_r;
  out_item_t        out_item_r;
  logic             load;
  logic             final_byte;

  assign load       = head_valid && (!out_valid_r || !out_stall);
  assign final_byte = (CNT_W'(idx_r + 1'b1) == head_cmd.count);
  assign pop        = load && final_byte;
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= final_byte ? '0 : idx_r + 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r.out_byte <= head_cmd.data[idx_r];
      out_item_r.out_last <= head_cmd.last && final_byte;
    end
  end

endmodule

[design/vlan_tag_strip_insert_core.sv]
// top level of the 802.1q vlan tag strip/insert block
// depends on vtsi_pkg, vtsi_front, vtsi_cmd_fifo, vtsi_back
//
//   channel  ports                                  direction
//   input    in_valid, in_stall, in_item            frame bytes in
//   output   out_valid, out_stall, out_item         rewritten bytes out
//   config   cfg_wr_en, cfg_wr_data                 push_tci write
//
// one input byte per cycle while not stalled; each gives zero to six output bytes
// back end drains a byte per cycle unless out_stall; queue of QUEUE_DEPTH bursts
// in_stall rises only while the burst queue is full
// synchronous active-low reset, no clearing pass; push_tci resets to 1

module vlan_tag_strip_insert_core import vtsi_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  in_item_t    in_item,
  output logic        in_stall,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        out_stall,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic push_valid, q_full, head_valid, pop;
  cmd_t push_cmd, head_cmd;

  vtsi_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_item     (in_item),
    .q_full      (q_full),
    .in_stall    (in_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push_valid  (push_valid),
    .push_cmd    (push_cmd)
  );

  vtsi_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  vtsi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .out_stall  (out_stall)
  );

endmodule

[design/vtsi_checker.sv]
// port-level checks for the vlan tag strip/insert block, bound to the top level
// depends on vtsi_pkg, vlan_tag_strip_insert_core

module vtsi_checker import vtsi_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input in_item_t    in_item,
  input logic        in_stall,
  input logic        out_valid,
  input out_item_t   out_item,
  input logic        out_stall,
  input logic        cfg_wr_en
);

  logic [3:0] frames_open_r;
  logic       in_end, out_end;

  assign in_end  = in_valid && !in_stall && in_item.in_last;
  assign out_end = out_valid && !out_stall && out_item.out_last;

  // frames whose last byte went in but not yet out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_open_r <= '0;
    end else if (in_end && !out_end) begin
      frames_open_r <= frames_open_r + 1'b1;
    end else if (out_end && !in_end) begin
      frames_open_r <= frames_open_r - 1'b1;
    end
  end

  a_out_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output transfer changed");

  a_no_early_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_end |-> frames_open_r != 4'd0)
    else $error("output frame ended before its input frame");

  a_open_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    frames_open_r != 4'd15)
    else $error("too many frames in flight");

  a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |-> !in_valid && !out_valid && frames_open_r == 4'd0)
    else $error("config write with transfers in flight");

endmodule

bind vlan_tag_strip_insert_core vtsi_checker u_vtsi_checker (.*);

[dv/tb_vlan_tag_strip_insert_core.sv]
// testbench for vlan_tag_strip_insert_core: random and directed frames, scoreboard on bytes
// depends on vtsi_pkg and the vlan_tag_strip_insert_core rtl

module tb_vlan_tag_strip_insert_core;
  import vtsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_item = '0;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_item;
  logic        out_stall = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  vlan_tag_strip_insert_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .out_stall  (out_stall),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  in_item_t    frame_bytes_q[$];
  out_item_t   rewritten_bytes_q[$];
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned frames_queued = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_in = 0;
  int unsigned bytes_out = 0;
  int unsigned tag_strips = 0;
  int unsigned tag_inserts = 0;

  // predictor state
  logic [15:0]      tci_model = 16'd1;
  logic [POS_W-1:0] frame_pos = '0;
  logic [7:0]       held_tag [HELD_DEPTH];
  logic             strip_tag = 1'b0;

  function automatic void push_rewritten(input logic [7:0] b, input logic lst);
    out_item_t o;
    o.out_byte = b;
    o.out_last = lst;
    rewritten_bytes_q.push_back(o);
  endfunction

  function automatic void rewrite_frame_byte(input in_item_t it);
    logic [7:0]  b;
    logic        lst;
    logic [15:0] etype;
    int          k;
    b = it.in_byte;
    lst = it.in_last;
    if (frame_pos < POS_ET_HI) begin
      push_rewritten(b, lst);
    end else if (frame_pos == POS_ET_HI) begin
      held_tag[0] = b;
      if (lst) push_rewritten(b, 1'b1);
    end else if (frame_pos == POS_ET_LO) begin
      etype = {held_tag[0], b};
      held_tag[1] = b;
      strip_tag = (etype == TPID_CTAG) || (etype == TPID_STAG);
      if (!strip_tag) begin
        tag_inserts++;
        push_rewritten(TPID_CTAG[15:8], 1'b0);
        push_rewritten(TPID_CTAG[7:0], 1'b0);
        push_rewritten(tci_model[15:8], 1'b0);
        push_rewritten(tci_model[7:0], 1'b0);
        push_rewritten(held_tag[0], 1'b0);
        push_rewritten(b, lst);
      end else if (lst) begin
        push_rewritten(held_tag[0], 1'b0);
        push_rewritten(b, 1'b1);
      end
    end else if ((frame_pos == POS_TAG_2 || frame_pos == POS_TAG_3) && strip_tag) begin
      held_tag[2'(frame_pos - POS_ET_HI)] = b;
      if (lst) begin
        for (k = 0; k < frame_pos - POS_ET_HI; k++) push_rewritten(held_tag[2'(k)], 1'b0);
        push_rewritten(b, 1'b1);
      end
    end else if (frame_pos == POS_INNER && strip_tag) begin
      if (lst) begin
        for (k = 0; k < HELD_DEPTH; k++) push_rewritten(held_tag[2'(k)], 1'b0);
      end else begin
        tag_strips++;
      end
      push_rewritten(b, lst);
    end else begin
      push_rewritten(b, lst);
    end
    if (lst) begin
      frame_pos = '0;
      strip_tag = 1'b0;
    end else if (frame_pos < POS_SAT) begin
      frame_pos = frame_pos + 1'b1;
    end
  endfunction

  // driver: one transfer per accepted byte, random gaps between
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        rewrite_frame_byte(in_item);
        bytes_in++;
      end
      if (!in_valid || !in_stall) begin
        if (frame_bytes_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_item <= frame_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      bytes_out++;
      if (rewritten_bytes_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t unexpected transfer: byte %h last %b", $realtime,
                   out_item.out_byte, out_item.out_last);
      end else begin
        want = rewritten_bytes_q.pop_front();
        if (want.out_byte !== out_item.out_byte || want.out_last !== out_item.out_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t mismatch: expected byte %h last %b, got byte %h last %b",
                     $realtime, want.out_byte, want.out_last,
                     out_item.out_byte, out_item.out_last);
        end
      end
    end
  end

  task automatic queue_frame(input int unsigned len, input logic [15:0] etype,
                             input int fill);
    in_item_t    it;
    int unsigned k;
    for (k = 0; k < len; k++) begin
      it.in_byte = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      if (k == 12) it.in_byte = etype[15:8];
      if (k == 13) it.in_byte = etype[7:0];
      it.in_last = (k == len - 1);
      frame_bytes_q.push_back(it);
    end
    frames_queued++;
    bytes_queued += len;
  endtask

  task automatic queue_random_frame();
    int unsigned len;
    int unsigned r;
    logic [15:0] etype;
    r = $urandom_range(99);
    if (r < 15) len = $urandom_range(12, 1);
    else if (r < 60) len = $urandom_range(19, 13);
    else len = $urandom_range(40, 20);
    r = $urandom_range(9);
    case (r)
      0, 1, 2: etype = TPID_CTAG;
      3, 4:    etype = TPID_STAG;
      5:       etype = {TPID_CTAG[15:8], 8'($urandom_range(255))};
      6:       etype = {TPID_STAG[15:8], 8'($urandom_range(255))};
      default: etype = 16'($urandom_range(16'hFFFF));
    endcase
    queue_frame(len, etype, -1);
  endtask

  task automatic wait_idle();
    while (frame_bytes_q.size() != 0 || in_valid || rewritten_bytes_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_push_tci(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tci_model = v;
  endtask

  initial begin
    int unsigned ph;
    int unsigned target;
    logic [15:0] tci_vals [4];
    int unsigned idle_vals [4];
    int unsigned stall_vals [4];
    tci_vals = '{16'hFFFF, 16'h0000, 16'($urandom_range(16'hFFFF)),
                 16'($urandom_range(16'hFFFF))};
    idle_vals = '{0, 52, 0, 38};
    stall_vals = '{0, 0, 52, 38};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: untagged frame ending on the decision byte, reset tci
    queue_frame(14, 16'h0000, 8'hFF);
    // tagged frame ending at the inner ethertype
    queue_frame(17, TPID_STAG, 8'h00);
    wait_idle();

    for (ph = 0; ph < 4; ph++) begin
      write_push_tci(tci_vals[ph]);
      sender_idle_pct = idle_vals[ph];
      recv_stall_pct = stall_vals[ph];
      target = bytes_queued + 30;
      while (bytes_queued < target) queue_random_frame();
      wait_idle();
    end

    $display("covered %0d frames, %0d bytes in, %0d bytes out", frames_queued, bytes_in,
             bytes_out);
    $display("%0d tags inserted, %0d tags stripped, 5 tci values, 4 idle/stall mixes",
             tag_inserts, tag_strips);
    if (mismatches == 0 && rewritten_bytes_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (rewritten_bytes_q.size() != 0)
        $display("%0d expected bytes never arrived", rewritten_bytes_q.size());
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d expected bytes pending", rewritten_bytes_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
design/vtsi_pkg.sv
design/vtsi_front.sv
design/vtsi_cmd_fifo.sv
design/vtsi_back.sv
design/vlan_tag_strip_insert_core.sv
design/vtsi_checker.sv
dv/tb_vlan_tag_strip_insert_core.sv
